FILE: design/npcl1_pkg.sv
// types, constants and helpers shared by the nearest palette color block
package npcl1_pkg;

    localparam int CH_W   = 8;
    localparam int IDX_W  = 3;
    localparam int DIST_W = 10;
    localparam int CFG_W  = 24;

    localparam logic [IDX_W-1:0] REG_COLOR_COUNT = 3'd0;
    localparam logic [IDX_W-1:0] REG_CENTER_ZERO = 3'd1;

    typedef struct packed {
        logic [CH_W-1:0] pix_ch2;
        logic [CH_W-1:0] pix_ch1;
        logic [CH_W-1:0] pix_ch0;
    } pix_t;

    typedef struct packed {
        logic [CH_W-1:0]  out_ch0;
        logic [CH_W-1:0]  out_ch1;
        logic [CH_W-1:0]  out_ch2;
        logic [IDX_W-1:0] center_index;
    } result_t;

    typedef struct packed {
        logic [CH_W-1:0] ch2;
        logic [CH_W-1:0] ch1;
        logic [CH_W-1:0] ch0;
    } center_t;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        logic [CH_W-1:0] r;
        begin
            r = (a > b) ? (a - b) : (b - a);
            return r;
        end
    endfunction

endpackage

FILE: design/npcl1_dist.sv
// l1 distance between one pixel and one palette center
module npcl1_dist
    import npcl1_pkg::*;
(
    input  pix_t              pix,
    input  center_t           center,
    output logic [DIST_W-1:0] distance
);

    assign distance = DIST_W'(abs_diff(pix.pix_ch0, center.ch0))
                    + DIST_W'(abs_diff(pix.pix_ch1, center.ch1))
                    + DIST_W'(abs_diff(pix.pix_ch2, center.ch2));

endmodule

FILE: design/npcl1_select.sv
// picks the active center with the smallest distance, lowest index on ties
module npcl1_select
    import npcl1_pkg::*;
#(
    parameter int N = 7
)
(
    input  logic [N-1:0][DIST_W-1:0] distance,
    input  logic [N-1:0]             active,
    output logic [IDX_W-1:0]         best
);

    logic [DIST_W-1:0] best_dist;

    always_comb
    begin
        best      = '0;
        best_dist = '1;
        for (int i = 0; i < N; i++)
        begin
            if (active[i] && (distance[i] < best_dist))
            begin
                best_dist = distance[i];
                best      = IDX_W'(i);
            end
        end
    end

endmodule

FILE: design/nearest_palette_color_l1_core.sv
// top level of the nearest palette color block, l1 metric
//
// usage:
//   input beat: pix is taken at a rising edge with start high and busy low.
//   busy is always low, so a pixel can be taken in every cycle.
//   result beat: done is high for exactly one cycle with result holding the
//   nearest active center's channels and index; it is taken at the edge
//   that ends that cycle.
//   pipeline: a pixel taken at an edge passes the input register and then
//   the result register before done goes high for it.
//   throughput: one pixel per cycle, set by the parallel distance units
//   and a single compare chain between the two registers.
//   config: cfg_we writes register cfg_index with cfg_data at a rising edge;
//   index 0 is color_count (0 reads as 1, clamped to MAX_COLORS), indices
//   1 up to 7 are centers zero to six. write only while no pixel is in flight.
//   reset: color_count returns to 1, all centers to 0, the pipeline empties.
//   the receiver cannot stall; results are never held back.
module nearest_palette_color_l1_core
    import npcl1_pkg::*;
#(
    parameter int MAX_COLORS = 7
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  pix_t             pix,
    output logic             done,
    output result_t          result,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam logic [IDX_W-1:0] MAX_CNT = IDX_W'(MAX_COLORS);

    logic [IDX_W-1:0]                 color_count_reg;
    center_t [MAX_COLORS-1:0]         center_reg;
    logic                             in_valid_reg;
    pix_t                             pix_reg;
    logic                             done_reg;
    result_t                          result_reg;
    result_t                          result_next;
    logic [IDX_W-1:0]                 eff_count;
    logic [MAX_COLORS-1:0]            active;
    logic [MAX_COLORS-1:0][DIST_W-1:0] distance;
    logic [IDX_W-1:0]                 best;
    center_t                          chosen;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_count_reg <= IDX_W'(1);
            center_reg      <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_COLOR_COUNT)
            begin
                color_count_reg <= cfg_data[IDX_W-1:0];
            end
            for (int i = 0; i < MAX_COLORS; i++)
            begin
                if (cfg_index == IDX_W'(int'(REG_CENTER_ZERO) + i))
                begin
                    center_reg[i] <= center_t'(cfg_data);
                end
            end
        end
    end

    always_comb
    begin
        priority if (color_count_reg == '0)
        begin
            eff_count = IDX_W'(1);
        end
        else if (color_count_reg > MAX_CNT)
        begin
            eff_count = MAX_CNT;
        end
        else
        begin
            eff_count = color_count_reg;
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_COLORS; g++)
        begin : g_dist
            assign active[g] = (IDX_W'(g) < eff_count);
            npcl1_dist u_dist
            (
                .pix      (pix_reg),
                .center   (center_reg[g]),
                .distance (distance[g])
            );
        end
    endgenerate

    npcl1_select #(.N(MAX_COLORS)) u_select
    (
        .distance (distance),
        .active   (active),
        .best     (best)
    );

    always_comb
    begin
        chosen = center_reg[0];
        for (int i = 0; i < MAX_COLORS; i++)
        begin
            if (best == IDX_W'(i))
            begin
                chosen = center_reg[i];
            end
        end
        result_next.out_ch0      = chosen.ch0;
        result_next.out_ch1      = chosen.ch1;
        result_next.out_ch2      = chosen.ch2;
        result_next.center_index = best;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            pix_reg <= pix;
        end
        if (in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

FILE: design/npcl1_chk.sv
// port-level checks for the nearest palette color block, with bind
module npcl1_chk
    import npcl1_pkg::*;
#(
    parameter int MAX_COLORS = 7
)
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_beat_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted beat gave no result");

    a_result_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result without accepted beat");

    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.center_index < IDX_W'(MAX_COLORS)))
        else $error("center index out of range");

endmodule

bind nearest_palette_color_l1_core npcl1_chk #(.MAX_COLORS(MAX_COLORS)) u_npcl1_chk
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
